FILE: sv/crsp_pkg.sv
// Shared types and constants of the cartridge ROM responder.
// Used by the front, the queue, the back and the top level; depends on nothing.
package crsp_pkg;

    localparam int SAMPLE_W = 12;
    localparam int IDX_W = 15;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int PWR_W = 4;
    localparam logic [PWR_W-1:0] PATCH_WRITES = 4'd10;

    localparam logic [2:0] OP_KEEP = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_VEC = 3'd2;
    localparam logic [2:0] OP_READ = 3'd3;
    localparam logic [2:0] OP_PATCH = 3'd4;

    localparam logic CFG_CLAMP_FLOOR = 1'b0;
    localparam logic CFG_CLAMP_CEILING = 1'b1;
    localparam logic [7:0] CLAMP_FLOOR_RST = 8'h0F;
    localparam logic [7:0] CLAMP_CEILING_RST = 8'h7F;

    localparam logic [15:0] VEC_LO_ADDR = 16'hFFFC;
    localparam logic [15:0] VEC_HI_ADDR = 16'hFFFD;
    localparam logic [7:0] VEC_LO_BYTE = 8'h00;
    localparam logic [7:0] VEC_HI_BYTE = 8'h88;
    localparam logic [15:0] MIRROR_LO_BUS = 16'h7FEA;
    localparam logic [15:0] MIRROR_HI_BUS = 16'h7FEB;
    localparam logic [15:0] MIRROR_LO_IMG = 16'h4FEA;
    localparam logic [15:0] MIRROR_HI_IMG = 16'h4FEB;

    typedef struct packed {
        logic [2:0] kind;
        logic rd_zero;
        logic [IDX_W-1:0] idx;
        logic [7:0] data;
        logic [3:0][SAMPLE_W-1:0] samples;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [IDX_W-1:0] patch_addr(input logic [PWR_W-1:0] step);
        logic [IDX_W-1:0] a;
        case (step)
            4'd0: a = 15'd17413;
            4'd1: a = 15'd17412;
            4'd2: a = 15'd17424;
            4'd3: a = 15'd17423;
            4'd4: a = 15'd17435;
            4'd5: a = 15'd17434;
            4'd6: a = 15'd17446;
            4'd7: a = 15'd17445;
            4'd8: a = 15'd17410;
            default: a = 15'd17411;
        endcase
        return a;
    endfunction

endpackage

FILE: sv/cart_rom_responder_with_sensor_patch_unit.sv
// Top level of the cartridge ROM responder with the sensor patch.
// Depends on crsp_pkg, crsp_front, crsp_queue and crsp_back.
//
// Each request on the slave stream yields exactly one response on the master
// stream. The front end takes one request per cycle into a four-entry queue
// while the queue is not full. The back end answers a load, a boot vector or
// a request that drives nothing from its idle state, and an image read from
// its read state, after the registered read of the single image memory port.
// A read of 0x7FEB then runs the patch: it shifts the sample windows, forms
// the window mean of each channel in turn, taken as a multiplication by the
// rounded-up reciprocal of the depth, and makes ten patch writes through the
// same memory port. The response of that read is registered as the patch
// starts. The image store is not cleared at reset and has no clearing pass;
// the core takes requests right after reset.
module cart_rom_responder_with_sensor_patch_unit #(
    parameter int IMAGE_LIMIT = 20479,
    parameter int WINDOW_DEPTH = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address[15:0], load_byte[23:16], sample_a[35:24], sample_b[47:36],
    // sample_c[59:48], sample_d[71:60]
    input  logic [crsp_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // data_byte[7:0]
    output logic [crsp_pkg::M_TDATA_W-1:0] m_tdata,
    // driven
    output logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [7:0]                     cfg_wr_data
);
    import crsp_pkg::*;

    logic [7:0] floor_reg;
    logic [7:0] ceiling_reg;
    q_status_t q_stat;
    logic push;
    logic pop;
    op_t op_in;
    op_t op_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= CLAMP_FLOOR_RST;
            ceiling_reg <= CLAMP_CEILING_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_CLAMP_FLOOR) begin
                floor_reg <= cfg_wr_data;
            end
            if (cfg_index == CFG_CLAMP_CEILING) begin
                ceiling_reg <= cfg_wr_data;
            end
        end
    end

    crsp_front #(
        .IMAGE_LIMIT(IMAGE_LIMIT)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .q_stat(q_stat),
        .push(push),
        .op(op_in)
    );

    crsp_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .op_in(op_in),
        .pop(pop),
        .op_out(op_head),
        .q_stat(q_stat)
    );

    crsp_back #(
        .IMAGE_LIMIT(IMAGE_LIMIT),
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_stat(q_stat),
        .head(op_head),
        .pop(pop),
        .clamp_floor(floor_reg),
        .clamp_ceiling(ceiling_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule

FILE: sv/crsp_front.sv
// Front end: accepts requests, tracks the boot handshake and classifies each request.
// Depends on crsp_pkg; feeds crsp_queue.
module crsp_front #(
    parameter int IMAGE_LIMIT = 20479
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [crsp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  crsp_pkg::q_status_t            q_stat,
    output logic                           push,
    output crsp_pkg::op_t                  op
);
    import crsp_pkg::*;

    localparam logic [15:0] LIMIT = 16'(IMAGE_LIMIT);
    localparam logic [1:0] BOOT_LO = 2'd0;
    localparam logic [1:0] BOOT_HI = 2'd1;
    localparam logic [1:0] BOOT_RUN = 2'd2;

    logic [1:0] boot_reg;
    logic [1:0] boot_next;
    logic [15:0] addr;
    logic [15:0] a_ext;

    assign s_tready = !q_stat.full;
    assign push = s_tvalid && !q_stat.full;
    assign addr = s_tdata[15:0];
    assign a_ext = {1'b0, addr[14:0]};

    always_comb begin
        boot_next = boot_reg;
        op.kind = OP_KEEP;
        op.rd_zero = 1'b0;
        op.idx = addr[14:0];
        op.data = s_tdata[23:16];
        op.samples[0] = s_tdata[35:24];
        op.samples[1] = s_tdata[47:36];
        op.samples[2] = s_tdata[59:48];
        op.samples[3] = s_tdata[71:60];
        if (!s_tuser) begin
            if (addr <= LIMIT) begin
                op.kind = OP_LOAD;
            end
        end else begin
            case (boot_reg)
                BOOT_LO: begin
                    if (addr == VEC_LO_ADDR) begin
                        op.kind = OP_VEC;
                        op.data = VEC_LO_BYTE;
                        boot_next = BOOT_HI;
                    end
                end
                BOOT_HI: begin
                    if (addr == VEC_HI_ADDR) begin
                        op.kind = OP_VEC;
                        op.data = VEC_HI_BYTE;
                        boot_next = BOOT_RUN;
                    end
                end
                default: begin
                    if (a_ext < LIMIT) begin
                        op.kind = OP_READ;
                    end else if (a_ext == MIRROR_LO_BUS) begin
                        if (MIRROR_LO_IMG <= LIMIT) begin
                            op.kind = OP_READ;
                            op.idx = MIRROR_LO_IMG[14:0];
                        end else begin
                            op.kind = OP_VEC;
                            op.data = 8'h00;
                        end
                    end else if (a_ext == MIRROR_HI_BUS) begin
                        op.kind = OP_PATCH;
                        op.idx = MIRROR_HI_IMG[14:0];
                        op.rd_zero = (MIRROR_HI_IMG > LIMIT);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_reg <= BOOT_LO;
        end else if (push) begin
            boot_reg <= boot_next;
        end
    end

endmodule

FILE: sv/crsp_queue.sv
// Short request queue between the front end and the back end.
// Depends on crsp_pkg for the request type and the depth.
module crsp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  crsp_pkg::op_t       op_in,
    input  logic                pop,
    output crsp_pkg::op_t       op_out,
    output crsp_pkg::q_status_t q_stat
);
    import crsp_pkg::*;

    op_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0] count_reg;

    assign op_out = entry_reg[rd_ptr_reg];
    assign q_stat.full = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/crsp_back.sv
// Back end: image store, result register, sample windows, reciprocal mean multiplier
// and patch writer. Depends on crsp_pkg; drains crsp_queue.
module crsp_back #(
    parameter int IMAGE_LIMIT = 20479,
    parameter int WINDOW_DEPTH = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  crsp_pkg::q_status_t            q_stat,
    input  crsp_pkg::op_t                  head,
    output logic                           pop,
    input  logic [7:0]                     clamp_floor,
    input  logic [7:0]                     clamp_ceiling,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [crsp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import crsp_pkg::*;

    localparam int IW = $clog2(IMAGE_LIMIT + 1);
    localparam int LG = $clog2(WINDOW_DEPTH);
    localparam int SW = SAMPLE_W + LG;
    localparam int SH = SW + LG;
    localparam int RECIP_INT = ((1 << SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam logic [SW:0] RECIP = (SW+1)'(RECIP_INT);
    localparam logic [IDX_W-1:0] LIMIT = IDX_W'(IMAGE_LIMIT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_MEAN = 3'd3;
    localparam logic [2:0] S_WR = 3'd4;

    logic [7:0] mem [0:IMAGE_LIMIT];
    logic [7:0] mem_q;
    logic mem_we;
    logic mem_re;
    logic [IDX_W-1:0] mem_idx;
    logic [7:0] mem_wdata;

    logic [2:0] state_reg, state_next;
    op_t cur_reg, cur_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic out_drv_reg, out_drv_next;
    logic [7:0] port_reg, port_next;
    logic [SAMPLE_W-1:0] win_reg [4][WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] win_next [4][WINDOW_DEPTH];
    logic [SW-1:0] sum_reg [4];
    logic [SW-1:0] sum_next [4];
    logic [SAMPLE_W-1:0] mean_reg [4];
    logic [SAMPLE_W-1:0] mean_next [4];
    logic [1:0] ch_reg, ch_next;
    logic [PWR_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic [2*SW:0] prod;
    logic out_free;
    logic [7:0] lvl;
    logic [7:0] lvl_floor;
    logic [7:0] patch_byte;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_drv_reg;
    assign out_free = !out_valid_reg || m_tready;

    // The window mean is the sum times a rounded-up reciprocal of the depth, exact
    // for every sum that fits in SW bits.
    assign prod = (2*SW+1)'(sum_reg[ch_reg]) * (2*SW+1)'(RECIP);

    always_comb begin
        lvl_floor = mean_reg[0][11:4];
        if (lvl_floor < clamp_floor) begin
            lvl_floor = clamp_floor;
        end
        lvl = (lvl_floor > clamp_ceiling) ? clamp_ceiling : lvl_floor;
    end

    always_comb begin
        case (wr_cnt_reg)
            4'd0: patch_byte = {4'b0, mean_reg[0][11:8]};
            4'd1: patch_byte = mean_reg[0][7:0];
            4'd2: patch_byte = {4'b0, mean_reg[1][11:8]};
            4'd3: patch_byte = mean_reg[1][7:0];
            4'd4: patch_byte = {7'b0, mean_reg[2][11]};
            4'd5: patch_byte = mean_reg[2][10:3];
            4'd6: patch_byte = {7'b0, mean_reg[3][11]};
            4'd7: patch_byte = mean_reg[3][10:3];
            default: patch_byte = lvl;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_drv_next = out_drv_reg;
        port_next = port_reg;
        win_next = win_reg;
        sum_next = sum_reg;
        mean_next = mean_reg;
        ch_next = ch_reg;
        wr_cnt_next = wr_cnt_reg;
        pop = 1'b0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_idx = head.idx;
        mem_wdata = head.data;
        case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty && out_free) begin
                    pop = 1'b1;
                    cur_next = head;
                    case (head.kind)
                        OP_LOAD: begin
                            mem_we = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next = port_reg;
                            out_drv_next = 1'b0;
                        end
                        OP_VEC: begin
                            port_next = head.data;
                            out_valid_next = 1'b1;
                            out_data_next = head.data;
                            out_drv_next = 1'b1;
                        end
                        OP_READ: begin
                            mem_re = 1'b1;
                            state_next = S_RD;
                        end
                        OP_PATCH: begin
                            if (head.rd_zero) begin
                                port_next = 8'h00;
                                out_valid_next = 1'b1;
                                out_data_next = 8'h00;
                                out_drv_next = 1'b1;
                                state_next = S_SHIFT;
                            end else begin
                                mem_re = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_data_next = port_reg;
                            out_drv_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD: begin
                port_next = mem_q;
                out_valid_next = 1'b1;
                out_data_next = mem_q;
                out_drv_next = 1'b1;
                state_next = (cur_reg.kind == OP_PATCH) ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                for (int c = 0; c < 4; c++) begin
                    sum_next[c] = sum_reg[c] - SW'(win_reg[c][0]) + SW'(cur_reg.samples[c]);
                    for (int k = 0; k + 1 < WINDOW_DEPTH; k++) begin
                        win_next[c][k] = win_reg[c][k+1];
                    end
                    win_next[c][WINDOW_DEPTH-1] = cur_reg.samples[c];
                end
                ch_next = 2'd0;
                state_next = S_MEAN;
            end
            S_MEAN: begin
                mean_next[ch_reg] = prod[SH +: SAMPLE_W];
                if (ch_reg == 2'd3) begin
                    wr_cnt_next = '0;
                    state_next = S_WR;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_WR: begin
                mem_idx = patch_addr(wr_cnt_reg);
                mem_wdata = patch_byte;
                mem_we = (mem_idx <= LIMIT);
                wr_cnt_next = wr_cnt_reg + 1'b1;
                if (wr_cnt_reg == PATCH_WRITES - 1'b1) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_idx[IW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_idx[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_data_reg <= out_data_next;
        out_drv_reg <= out_drv_next;
        mean_reg <= mean_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            port_reg <= 8'h00;
            ch_reg <= '0;
            wr_cnt_reg <= '0;
            for (int c = 0; c < 4; c++) begin
                sum_reg[c] <= '0;
                for (int k = 0; k < WINDOW_DEPTH; k++) begin
                    win_reg[c][k] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            port_reg <= port_next;
            ch_reg <= ch_next;
            wr_cnt_reg <= wr_cnt_next;
            sum_reg <= sum_next;
            win_reg <= win_next;
        end
    end

endmodule

FILE: dv/cart_rom_responder_with_sensor_patch_unit_tb.sv
// Self-checking testbench for the cartridge ROM responder with the sensor patch.
// Drives image loads and bus reads, predicts every response and checks it.
// Depends on crsp_pkg and cart_rom_responder_with_sensor_patch_unit.
`timescale 1ns / 1ps

module cart_rom_responder_with_sensor_patch_unit_tb;

    localparam int IMAGE_LIMIT = 20479;
    localparam int WINDOW_DEPTH = 12;
    localparam int SAMPLE_W = crsp_pkg::SAMPLE_W;
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int REPORT_LIMIT = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [15:0] RESET_VEC_LO = 16'hFFFC;
    localparam logic [15:0] RESET_VEC_HI = 16'hFFFD;
    localparam logic [7:0] RESET_VEC_LO_BYTE = 8'h00;
    localparam logic [7:0] RESET_VEC_HI_BYTE = 8'h88;
    localparam logic [15:0] BUS_MIRROR_LO = 16'h7FEA;
    localparam logic [15:0] BUS_MIRROR_HI = 16'h7FEB;
    localparam int IMG_MIRROR_LO = 16'h4FEA;
    localparam int IMG_MIRROR_HI = 16'h4FEB;

    localparam int LEVEL_IDX = 17410;
    localparam int MEAN_A_IDX = 17412;
    localparam int MEAN_B_IDX = 17423;
    localparam int MEAN_C_IDX = 17434;
    localparam int MEAN_D_IDX = 17445;

    typedef enum logic [1:0] {
        BOOT_WAIT_LO,
        BOOT_WAIT_HI,
        BOOT_RUN
    } boot_stage_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic driven;
    } port_word_t;

    class rom_image_tracker;
        bit [7:0] image [IMAGE_LIMIT+1];
        bit written [IMAGE_LIMIT+1];
        int unsigned filled [$];
        bit [SAMPLE_W-1:0] window [4][WINDOW_DEPTH];
        int unsigned window_sum [4];
        boot_stage_t boot;
        logic [7:0] port_byte;
        logic [7:0] floor_lvl;
        logic [7:0] ceil_lvl;
        port_word_t pending [$];
        int mismatches;
        int checked;
        int loads;
        int driven_count;
        int patches;

        function new();
            boot = BOOT_WAIT_LO;
            port_byte = 8'h00;
            floor_lvl = 8'h0F;
            ceil_lvl = 8'h7F;
            mismatches = 0;
            checked = 0;
            loads = 0;
            driven_count = 0;
            patches = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] value);
            if (idx == crsp_pkg::CFG_CLAMP_FLOOR) begin
                floor_lvl = value;
            end else begin
                ceil_lvl = value;
            end
        endfunction

        function void store_byte(int unsigned idx, logic [7:0] value);
            if (idx <= IMAGE_LIMIT) begin
                image[idx] = value;
                if (!written[idx]) begin
                    written[idx] = 1'b1;
                    filled.push_back(idx);
                end
            end
        endfunction

        function logic [7:0] fetch_byte(int unsigned idx);
            if (idx > IMAGE_LIMIT) begin
                return 8'h00;
            end
            return image[idx];
        endfunction

        function int unsigned window_mean(int ch, logic [SAMPLE_W-1:0] sample);
            int k;
            window_sum[ch] -= window[ch][0];
            for (k = 0; k < WINDOW_DEPTH - 1; k++) begin
                window[ch][k] = window[ch][k+1];
            end
            window[ch][WINDOW_DEPTH-1] = sample;
            window_sum[ch] += sample;
            return window_sum[ch] / WINDOW_DEPTH;
        endfunction

        function void store_word(int unsigned lo_idx, int unsigned value);
            store_byte(lo_idx + 1, value[15:8]);
            store_byte(lo_idx, value[7:0]);
        endfunction

        function void run_patch(logic [3:0][SAMPLE_W-1:0] smp);
            int unsigned mean [4];
            logic [7:0] level;
            int ch;
            for (ch = 0; ch < 4; ch++) begin
                mean[ch] = window_mean(ch, smp[ch]);
            end
            store_word(MEAN_A_IDX, mean[0]);
            store_word(MEAN_B_IDX, mean[1]);
            store_word(MEAN_C_IDX, mean[2] / 8);
            store_word(MEAN_D_IDX, mean[3] / 8);
            level = 8'(mean[0] >> 4);
            if (level < floor_lvl) begin
                level = floor_lvl;
            end
            if (level > ceil_lvl) begin
                level = ceil_lvl;
            end
            store_byte(LEVEL_IDX, level);
            store_byte(LEVEL_IDX + 1, level);
            patches++;
        endfunction

        function void note_request(logic cmd, logic [15:0] addr, logic [7:0] load_byte,
                                   logic [3:0][SAMPLE_W-1:0] smp);
            logic drove;
            int unsigned a;
            drove = 1'b0;
            a = 32'(addr[14:0]);
            if (cmd == CMD_LOAD) begin
                store_byte(32'(addr), load_byte);
                loads++;
            end else if (boot == BOOT_WAIT_LO) begin
                if (addr == RESET_VEC_LO) begin
                    port_byte = RESET_VEC_LO_BYTE;
                    drove = 1'b1;
                    boot = BOOT_WAIT_HI;
                end
            end else if (boot == BOOT_WAIT_HI) begin
                if (addr == RESET_VEC_HI) begin
                    port_byte = RESET_VEC_HI_BYTE;
                    drove = 1'b1;
                    boot = BOOT_RUN;
                end
            end else if (a < IMAGE_LIMIT) begin
                port_byte = fetch_byte(a);
                drove = 1'b1;
            end else if (a == BUS_MIRROR_LO) begin
                port_byte = fetch_byte(IMG_MIRROR_LO);
                drove = 1'b1;
            end else if (a == BUS_MIRROR_HI) begin
                port_byte = fetch_byte(IMG_MIRROR_HI);
                drove = 1'b1;
                run_patch(smp);
            end
            if (drove) begin
                driven_count++;
            end
            pending.push_back('{data_byte: port_byte, driven: drove});
        endfunction

        function void check_response(logic [7:0] data_byte, logic driven);
            port_word_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected response: data_byte %02h driven %0b",
                             data_byte, driven);
                end
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.data_byte !== data_byte || want.driven !== driven) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("response %0d: data_byte exp %02h got %02h, driven exp %0b got %0b",
                             checked, want.data_byte, data_byte, want.driven, driven);
                end
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [crsp_pkg::S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [crsp_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_wr_en;
    logic cfg_index;
    logic [7:0] cfg_wr_data;

    rom_image_tracker sb;
    bit gaps_on;
    int quiet_cycles = 0;

    cart_rom_responder_with_sensor_patch_unit #(
        .IMAGE_LIMIT(IMAGE_LIMIT),
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_request(input logic cmd, input logic [15:0] addr,
                                input logic [7:0] load_byte,
                                input logic [3:0][SAMPLE_W-1:0] smp);
        @(negedge aclk);
        while (gaps_on && $urandom_range(99) < 23) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {smp[3], smp[2], smp[1], smp[0], load_byte, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, addr, load_byte, smp);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic logic [3:0][SAMPLE_W-1:0] draw_samples();
        logic [3:0][SAMPLE_W-1:0] smp;
        int unsigned lo;
        int unsigned hi;
        int ch;
        case ($urandom_range(3))
            0: begin
                lo = 0;
                hi = 4095;
            end
            1: begin
                lo = 0;
                hi = 300;
            end
            2: begin
                lo = 3700;
                hi = 4095;
            end
            default: begin
                lo = $urandom_range(4095);
                hi = lo;
            end
        endcase
        for (ch = 0; ch < 4; ch++) begin
            smp[ch] = SAMPLE_W'($urandom_range(hi, lo));
        end
        return smp;
    endfunction

    function automatic logic [15:0] readable_addr();
        int unsigned idx;
        logic [15:0] addr;
        do idx = sb.filled[$urandom_range(sb.filled.size() - 1)]; while (idx >= IMAGE_LIMIT);
        addr = 16'(idx);
        addr[15] = 1'($urandom_range(1));
        return addr;
    endfunction

    task automatic random_request();
        int unsigned pick;
        int unsigned idx;
        logic [15:0] addr;
        logic cmd;
        pick = $urandom_range(99);
        cmd = CMD_READ;
        if (pick < 20) begin
            cmd = CMD_LOAD;
            case ($urandom_range(3))
                0: addr = 16'($urandom);
                1: addr = 16'($urandom_range(MEAN_D_IDX + 1, LEVEL_IDX));
                default: addr = 16'($urandom_range(IMAGE_LIMIT));
            endcase
        end else if (pick < 60) begin
            addr = readable_addr();
        end else if (pick < 70) begin
            idx = $urandom_range(MEAN_D_IDX + 1, LEVEL_IDX);
            if (!sb.written[idx]) begin
                idx = LEVEL_IDX;
            end
            addr = 16'(idx);
            addr[15] = 1'($urandom_range(1));
        end else if (pick < 85) begin
            addr = BUS_MIRROR_HI;
            addr[15] = 1'($urandom_range(1));
        end else if (pick < 90) begin
            addr = BUS_MIRROR_LO;
            addr[15] = 1'($urandom_range(1));
        end else begin
            do addr = 16'($urandom_range(16'h7FFF, IMAGE_LIMIT));
            while (addr == BUS_MIRROR_LO || addr == BUS_MIRROR_HI);
            addr[15] = 1'($urandom_range(1));
        end
        send_request(cmd, addr, 8'($urandom), draw_samples());
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = !(gaps_on && $urandom_range(99) < 23);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_response(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("cart_rom_responder_with_sensor_patch_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0] fl;
        logic [7:0] cl;
        int p;
        int n;
        sb = new();
        gaps_on = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        cfg_wr_en = 1'b0;
        cfg_index = crsp_pkg::CFG_CLAMP_FLOOR;
        cfg_wr_data = 8'h00;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Image loads at the edges of the store, and loads past it that are dropped.
        send_request(CMD_LOAD, 16'h0000, 8'hFF, draw_samples());
        send_request(CMD_LOAD, 16'h4FFE, 8'h00, draw_samples());
        send_request(CMD_LOAD, 16'(IMG_MIRROR_LO), 8'($urandom), draw_samples());
        send_request(CMD_LOAD, 16'(IMG_MIRROR_HI), 8'($urandom), draw_samples());
        send_request(CMD_LOAD, 16'h4FFF, 8'h5A, draw_samples());
        send_request(CMD_LOAD, 16'h5000, 8'h33, draw_samples());
        send_request(CMD_LOAD, 16'hFFFF, 8'hC3, draw_samples());

        // Boot handshake, with stray reads before and between the two vectors.
        send_request(CMD_READ, 16'h0000, 8'h00, draw_samples());
        send_request(CMD_READ, RESET_VEC_HI, 8'h00, draw_samples());
        send_request(CMD_READ, RESET_VEC_LO, 8'h00, draw_samples());
        send_request(CMD_READ, RESET_VEC_LO, 8'h00, draw_samples());
        send_request(CMD_READ, BUS_MIRROR_HI, 8'h00, draw_samples());
        send_request(CMD_READ, RESET_VEC_HI, 8'h00, draw_samples());

        // Running reads: masking, the image edge, the mirrors and the patch.
        send_request(CMD_READ, 16'h0000, 8'h00, draw_samples());
        send_request(CMD_READ, 16'h8000, 8'h00, draw_samples());
        send_request(CMD_READ, 16'h4FFE, 8'h00, draw_samples());
        send_request(CMD_READ, 16'hCFFE, 8'h00, draw_samples());
        send_request(CMD_READ, 16'h4FFF, 8'h00, draw_samples());
        send_request(CMD_READ, 16'hFFFF, 8'h00, draw_samples());
        send_request(CMD_READ, BUS_MIRROR_LO, 8'h00, draw_samples());
        send_request(CMD_READ, BUS_MIRROR_HI, 8'h00, {4{12'hFFF}});
        send_request(CMD_READ, 16'hFFEB, 8'h00, '0);
        send_request(CMD_READ, 16'(LEVEL_IDX), 8'h00, draw_samples());
        send_request(CMD_READ, 16'(MEAN_A_IDX + 1), 8'h00, draw_samples());
        send_request(CMD_READ, 16'(MEAN_D_IDX + 1), 8'h00, draw_samples());

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: begin
                        fl = 8'h00;
                        cl = 8'hFF;
                    end
                    2: begin
                        fl = 8'hFF;
                        cl = 8'h00;
                    end
                    3: begin
                        fl = 8'd200;
                        cl = 8'd60;
                    end
                    4: begin
                        fl = 8'd128;
                        cl = 8'd128;
                    end
                    5: begin
                        fl = 8'h00;
                        cl = 8'h00;
                    end
                    6: begin
                        fl = 8'hFF;
                        cl = 8'hFF;
                    end
                    default: begin
                        fl = 8'($urandom);
                        cl = 8'($urandom);
                    end
                endcase
                write_register(crsp_pkg::CFG_CLAMP_FLOOR, fl);
                write_register(crsp_pkg::CFG_CLAMP_CEILING, cl);
            end
            gaps_on = (p != 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                random_request();
            end
        end

        wait_drained();
        $display("covered %0d requests: %0d loads, %0d driven bytes, %0d sensor patches",
                 sb.checked, sb.loads, sb.driven_count, sb.patches);
        $display("clamp settings tried: %0d, mismatches: %0d", PHASES, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("cart_rom_responder_with_sensor_patch_unit regression: pass");
        end else begin
            $display("cart_rom_responder_with_sensor_patch_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/crsp_pkg.sv
sv/crsp_front.sv
sv/crsp_queue.sv
sv/crsp_back.sv
sv/cart_rom_responder_with_sensor_patch_unit.sv
dv/cart_rom_responder_with_sensor_patch_unit_tb.sv
